@@ rtl/tgce_pkg.sv @@
// Shared types and constants for the text grid cursor editor.
// Used by text_grid_cursor_editor_core; depends on nothing else.
package tgce_pkg;

    localparam int MAX_ROWS = 64;
    localparam int MAX_COLS = 128;

    // Row and column index widths, and widths of the counts that can reach the limits.
    localparam int ROW_W  = $clog2(MAX_ROWS);
    localparam int COL_W  = $clog2(MAX_COLS);
    localparam int RCNT_W = ROW_W + 1;
    localparam int CCNT_W = COL_W + 1;
    localparam int GADDR_W = ROW_W + COL_W;

    localparam int CHAR_W  = 8;
    localparam int FUNC_W  = 3;
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    // Register indexes on the configuration port.
    localparam logic REG_ROWS_IN_USE = 1'b0;
    localparam logic REG_COLS_IN_USE = 1'b1;

    typedef enum logic [FUNC_W-1:0] {
        F_LOAD_CH  = 3'd0,
        F_LOAD_EOL = 3'd1,
        F_LEFT     = 3'd2,
        F_RIGHT    = 3'd3,
        F_DELETE   = 3'd4,
        F_INSERT   = 3'd5,
        F_READ     = 3'd6,
        F_NOP      = 3'd7
    } t_func;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LEN,
        S_SHIFT,
        S_PUT,
        S_WRAP,
        S_TAIL,
        S_LLEN,
        S_SCAN,
        S_OUT
    } t_state;

endpackage

@@ rtl/text_grid_cursor_editor_core.sv @@
// Text grid cursor editor: grid and row-length memories, cursor, load row and print range.
// Depends on tgce_pkg for widths, function codes and the sequencer state type.
//
// The block takes one item at a time and holds o_ready low until the result beat has
// been taken. An item passes through the accept in S_IDLE, the length lookups in S_LEN,
// S_TAIL and S_LLEN, a scan over the rows in use (1 to 64) in S_SCAN that rebuilds the
// print range from the per-row non-empty flags, and S_OUT, where the result beat is
// offered. DELETE and INSERT add an S_SHIFT pass, and INSERT also S_PUT, since the grid
// memory moves one character per cycle through its single read and single write port;
// LEFT across a row start adds S_WRAP. The result then waits in its output register
// until i_ready. Row lengths read as zero until written through per-row flags, so no
// clearing pass follows reset.
module text_grid_cursor_editor_core import tgce_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // configuration port
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [PADDR_W-1:0]  paddr,
    input  logic [PDATA_W-1:0]  pwdata,
    output logic [PDATA_W-1:0]  prdata,
    output logic                pready,
    // input items
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [FUNC_W-1:0]   i_func,
    input  logic [CHAR_W-1:0]   i_ch,
    input  logic [ROW_W-1:0]    i_read_row,
    input  logic [COL_W-1:0]    i_read_col,
    // result items
    output logic                o_valid,
    input  logic                i_ready,
    output logic [ROW_W-1:0]    o_cursor_row,
    output logic [CCNT_W-1:0]   o_cursor_col,
    output logic [CHAR_W-1:0]   o_cell_char,
    output logic [CCNT_W-1:0]   o_line_length,
    output logic [RCNT_W-1:0]   o_print_rows,
    output logic                o_applied
);

    t_state               r_state, n_state;
    t_func                r_func, n_func;
    logic [CHAR_W-1:0]    r_ch, n_ch;
    logic [COL_W-1:0]     r_rc, n_rc;
    logic [ROW_W-1:0]     r_cur_row, n_cur_row;
    logic [CCNT_W-1:0]    r_cur_col, n_cur_col;
    logic [RCNT_W-1:0]    r_load_row, n_load_row;
    logic [RCNT_W-1:0]    r_print_range, n_print_range;
    logic [MAX_ROWS-1:0]  r_flag, n_flag;
    logic [CHAR_W-1:0]    r_cell_char, n_cell_char;
    logic [CCNT_W-1:0]    r_line_len, n_line_len;
    logic                 r_applied, n_applied;
    logic [COL_W-1:0]     r_cnt, n_cnt;
    logic [COL_W-1:0]     r_idx, n_idx;
    logic                 r_pend, n_pend;
    logic [COL_W-1:0]     r_pdst, n_pdst;
    logic [ROW_W-1:0]     r_scan, n_scan;
    logic [RCNT_W-1:0]    r_rows;
    logic [CCNT_W-1:0]    r_cols;

    // Memories and their ports.
    logic [CHAR_W-1:0]    r_grid [MAX_ROWS*MAX_COLS];
    logic [CHAR_W-1:0]    r_grid_q;
    logic                 grid_we;
    logic [GADDR_W-1:0]   grid_waddr;
    logic [GADDR_W-1:0]   grid_raddr;
    logic [CHAR_W-1:0]    grid_wdata;

    logic [CCNT_W-1:0]    r_rlen [MAX_ROWS];
    logic [CCNT_W-1:0]    r_rl_q;
    logic [ROW_W-1:0]     r_rl_addr_q;
    logic                 rl_we;
    logic [ROW_W-1:0]     rl_waddr;
    logic [ROW_W-1:0]     rl_raddr;
    logic [CCNT_W-1:0]    rl_wdata;

    logic [RCNT_W-1:0]    eff_rows;
    logic [CCNT_W-1:0]    eff_cols;
    logic [CCNT_W-1:0]    len_val;
    logic [COL_W-1:0]     shift_src;
    logic                 cfg_wr;

    // Configuration registers.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_comb begin
        case (paddr[2])
            REG_ROWS_IN_USE: prdata = PDATA_W'(r_rows);
            REG_COLS_IN_USE: prdata = PDATA_W'(r_cols);
            default:         prdata = '0;
        endcase
    end

    always_comb begin
        eff_rows = r_rows;
        if (r_rows == '0) begin
            eff_rows = RCNT_W'(1);
        end else if (r_rows > RCNT_W'(MAX_ROWS)) begin
            eff_rows = RCNT_W'(MAX_ROWS);
        end
        eff_cols = r_cols;
        if (r_cols == '0) begin
            eff_cols = CCNT_W'(1);
        end else if (r_cols > CCNT_W'(MAX_COLS)) begin
            eff_cols = CCNT_W'(MAX_COLS);
        end
    end

    // A row length whose flag is clear has never been written or has become empty.
    assign len_val   = r_flag[r_rl_addr_q] ? r_rl_q : '0;
    assign shift_src = (r_func == F_DELETE) ? r_idx + COL_W'(1) : r_idx - COL_W'(1);

    assign o_ready       = (r_state == S_IDLE);
    assign o_valid       = (r_state == S_OUT);
    assign o_cursor_row  = r_cur_row;
    assign o_cursor_col  = r_cur_col;
    assign o_cell_char   = r_cell_char;
    assign o_line_length = r_line_len;
    assign o_print_rows  = r_print_range;
    assign o_applied     = r_applied;

    always_comb begin
        n_state       = r_state;
        n_func        = r_func;
        n_ch          = r_ch;
        n_rc          = r_rc;
        n_cur_row     = r_cur_row;
        n_cur_col     = r_cur_col;
        n_load_row    = r_load_row;
        n_print_range = r_print_range;
        n_flag        = r_flag;
        n_cell_char   = r_cell_char;
        n_line_len    = r_line_len;
        n_applied     = r_applied;
        n_cnt         = r_cnt;
        n_idx         = r_idx;
        n_pend        = r_pend;
        n_pdst        = r_pdst;
        n_scan        = r_scan;
        grid_we       = 1'b0;
        grid_waddr    = {r_cur_row, r_pdst};
        grid_wdata    = r_grid_q;
        grid_raddr    = {r_cur_row, shift_src};
        rl_we         = 1'b0;
        rl_waddr      = r_cur_row;
        rl_wdata      = '0;
        rl_raddr      = r_cur_row;

        case (r_state)
            S_IDLE: begin
                grid_raddr = {i_read_row, i_read_col};
                case (t_func'(i_func))
                    F_LOAD_CH: rl_raddr = r_load_row[ROW_W-1:0];
                    F_READ:    rl_raddr = i_read_row;
                    default:   rl_raddr = r_cur_row;
                endcase
                if (i_valid) begin
                    n_func      = t_func'(i_func);
                    n_ch        = i_ch;
                    n_rc        = i_read_col;
                    n_cell_char = '0;
                    n_applied   = 1'b0;
                    n_state     = S_LEN;
                end
            end

            S_LEN: begin
                n_state = S_TAIL;
                case (r_func)
                    F_LOAD_CH: begin
                        if (r_ch != '0 && r_load_row < eff_rows && len_val < eff_cols) begin
                            grid_we    = 1'b1;
                            grid_waddr = {r_load_row[ROW_W-1:0], len_val[COL_W-1:0]};
                            grid_wdata = r_ch;
                            rl_we      = 1'b1;
                            rl_waddr   = r_load_row[ROW_W-1:0];
                            rl_wdata   = len_val + CCNT_W'(1);
                            n_flag[r_load_row[ROW_W-1:0]] = 1'b1;
                            n_applied  = 1'b1;
                        end
                    end
                    F_LOAD_EOL: begin
                        if (r_load_row < eff_rows) begin
                            n_load_row = r_load_row + RCNT_W'(1);
                        end
                    end
                    F_LEFT: begin
                        if (r_cur_row != '0 && r_cur_col == '0) begin
                            // Wrap to the end of the previous row: fetch its length first.
                            n_cur_row = r_cur_row - ROW_W'(1);
                            rl_raddr  = r_cur_row - ROW_W'(1);
                            n_applied = 1'b1;
                            n_state   = S_WRAP;
                        end else if (r_cur_col != '0) begin
                            n_cur_col = r_cur_col - CCNT_W'(1);
                            n_applied = 1'b1;
                        end
                    end
                    F_RIGHT: begin
                        if ({1'b0, r_cur_row} + RCNT_W'(1) < eff_rows && r_cur_col == len_val) begin
                            n_cur_row = r_cur_row + ROW_W'(1);
                            n_cur_col = '0;
                            n_applied = 1'b1;
                        end else if (r_cur_col < len_val) begin
                            n_cur_col = r_cur_col + CCNT_W'(1);
                            n_applied = 1'b1;
                        end
                    end
                    F_DELETE: begin
                        if (r_cur_col < len_val) begin
                            rl_we     = 1'b1;
                            rl_wdata  = len_val - CCNT_W'(1);
                            n_flag[r_cur_row] = (len_val != CCNT_W'(1));
                            n_cnt     = COL_W'(len_val - r_cur_col - CCNT_W'(1));
                            n_idx     = r_cur_col[COL_W-1:0];
                            n_pend    = 1'b0;
                            n_applied = 1'b1;
                            n_state   = S_SHIFT;
                        end
                    end
                    F_INSERT: begin
                        if (r_ch != '0 && len_val < eff_cols && r_cur_col <= len_val) begin
                            rl_we     = 1'b1;
                            rl_wdata  = len_val + CCNT_W'(1);
                            n_flag[r_cur_row] = 1'b1;
                            n_cnt     = COL_W'(len_val - r_cur_col);
                            n_idx     = len_val[COL_W-1:0];
                            n_pend    = 1'b0;
                            n_applied = 1'b1;
                            n_state   = S_SHIFT;
                        end
                    end
                    F_READ: begin
                        if ({1'b0, r_rc} < len_val) begin
                            n_cell_char = r_grid_q;
                        end
                    end
                    default: begin
                    end
                endcase
            end

            S_SHIFT: begin
                // One character per cycle: the read issued now is written back next cycle.
                if (r_pend) begin
                    grid_we = 1'b1;
                end
                if (r_cnt != '0) begin
                    n_pdst = r_idx;
                    n_pend = 1'b1;
                    n_idx  = shift_src;
                    n_cnt  = r_cnt - COL_W'(1);
                end else begin
                    n_pend  = 1'b0;
                    n_state = (r_func == F_INSERT) ? S_PUT : S_TAIL;
                end
            end

            S_PUT: begin
                grid_we    = 1'b1;
                grid_waddr = {r_cur_row, r_cur_col[COL_W-1:0]};
                grid_wdata = r_ch;
                n_state    = S_TAIL;
            end

            S_WRAP: begin
                n_cur_col = len_val;
                n_state   = S_TAIL;
            end

            S_TAIL: begin
                rl_raddr      = r_cur_row;
                n_scan        = '0;
                n_print_range = '0;
                n_state       = S_LLEN;
            end

            S_LLEN: begin
                n_line_len = len_val;
                n_state    = S_SCAN;
            end

            S_SCAN: begin
                if (r_flag[r_scan]) begin
                    n_print_range = {1'b0, r_scan} + RCNT_W'(1);
                end
                if ({1'b0, r_scan} == eff_rows - RCNT_W'(1)) begin
                    n_state = S_OUT;
                end else begin
                    n_scan = r_scan + ROW_W'(1);
                end
            end

            S_OUT: begin
                if (i_ready) begin
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_cur_row     <= '0;
            r_cur_col     <= '0;
            r_load_row    <= '0;
            r_print_range <= '0;
            r_flag        <= '0;
            r_pend        <= 1'b0;
            r_rows        <= RCNT_W'(MAX_ROWS);
            r_cols        <= CCNT_W'(MAX_COLS);
        end else begin
            r_state       <= n_state;
            r_cur_row     <= n_cur_row;
            r_cur_col     <= n_cur_col;
            r_load_row    <= n_load_row;
            r_print_range <= n_print_range;
            r_flag        <= n_flag;
            r_pend        <= n_pend;
            if (cfg_wr && paddr[2] == REG_ROWS_IN_USE) begin
                r_rows <= pwdata[RCNT_W-1:0];
            end
            if (cfg_wr && paddr[2] == REG_COLS_IN_USE) begin
                r_cols <= pwdata[CCNT_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_func      <= n_func;
        r_ch        <= n_ch;
        r_rc        <= n_rc;
        r_cell_char <= n_cell_char;
        r_line_len  <= n_line_len;
        r_applied   <= n_applied;
        r_cnt       <= n_cnt;
        r_idx       <= n_idx;
        r_pdst      <= n_pdst;
        r_scan      <= n_scan;
        r_rl_addr_q <= rl_raddr;
    end

    always_ff @(posedge i_clk) begin
        if (grid_we) begin
            r_grid[grid_waddr] <= grid_wdata;
        end
        r_grid_q <= r_grid[grid_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (rl_we) begin
            r_rlen[rl_waddr] <= rl_wdata;
        end
        r_rl_q <= r_rlen[rl_raddr];
    end

    // The cursor never lies beyond the end of its own row in a result beat.
    a_cursor_in_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_cursor_col <= o_line_length))
        else $error("cursor column beyond row length");

    // The print range covers only rows in use.
    a_print_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_print_rows <= eff_rows))
        else $error("print range beyond rows in use");

    // Each issued shift read lowers the move count by exactly one.
    a_shift_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SHIFT && r_cnt != '0) |=> (r_cnt == $past(r_cnt) - COL_W'(1)))
        else $error("shift move count out of step");

    // A write-back in the shift loop always follows a read issued the cycle before.
    a_shift_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SHIFT && r_pend) |-> $past(r_state == S_SHIFT && r_cnt != '0))
        else $error("shift write-back without a pending read");

    // The load row never passes the rows in use by more than the saturation step.
    a_load_row_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LEN && r_func == F_LOAD_EOL && r_load_row >= eff_rows)
            |=> (r_load_row == $past(r_load_row)))
        else $error("load row advanced past saturation");

endmodule

@@ tb/testbench.sv @@
// Self-checking testbench for text_grid_cursor_editor_core: directed table, then random edits.
// Depends on tgce_pkg and the core RTL; holds its own model of the grid, cursor and print range.
module testbench;
    import tgce_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [PADDR_W-1:0] ADDR_ROWS = {REG_ROWS_IN_USE, 2'b00};
    localparam logic [PADDR_W-1:0] ADDR_COLS = {REG_COLS_IN_USE, 2'b00};

    typedef struct packed {
        t_func             func;
        logic [CHAR_W-1:0] ch;
        logic [ROW_W-1:0]  read_row;
        logic [COL_W-1:0]  read_col;
    } t_edit_item;

    typedef struct packed {
        logic [ROW_W-1:0]  cursor_row;
        logic [CCNT_W-1:0] cursor_col;
        logic [CHAR_W-1:0] cell_char;
        logic [CCNT_W-1:0] line_length;
        logic [RCNT_W-1:0] print_rows;
        logic              applied;
    } t_edit_result;

    // One row of the directed table: a register write or an edit beat.
    typedef struct {
        bit                 is_reg;
        logic [PADDR_W-1:0] addr;
        logic [PDATA_W-1:0] value;
        t_edit_item         item;
        bit                 typed;
        t_edit_result       want;
    } t_step;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [PDATA_W-1:0] pwdata = '0;
    logic [PDATA_W-1:0] prdata;
    logic               pready;
    logic               i_valid = 1'b0;
    logic               o_ready;
    logic [FUNC_W-1:0]  i_func = '0;
    logic [CHAR_W-1:0]  i_ch = '0;
    logic [ROW_W-1:0]   i_read_row = '0;
    logic [COL_W-1:0]   i_read_col = '0;
    logic               o_valid;
    logic               i_ready = 1'b0;
    logic [ROW_W-1:0]   o_cursor_row;
    logic [CCNT_W-1:0]  o_cursor_col;
    logic [CHAR_W-1:0]  o_cell_char;
    logic [CCNT_W-1:0]  o_line_length;
    logic [RCNT_W-1:0]  o_print_rows;
    logic               o_applied;

    text_grid_cursor_editor_core i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_func       (i_func),
        .i_ch         (i_ch),
        .i_read_row   (i_read_row),
        .i_read_col   (i_read_col),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_cursor_row (o_cursor_row),
        .o_cursor_col (o_cursor_col),
        .o_cell_char  (o_cell_char),
        .o_line_length(o_line_length),
        .o_print_rows (o_print_rows),
        .o_applied    (o_applied)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Shadow copy of the editor state.
    logic [CHAR_W-1:0] text_cells [MAX_ROWS][MAX_COLS];
    int unsigned       line_len [MAX_ROWS];
    int unsigned       cursor_r, cursor_c, load_row_m;
    logic [RCNT_W-1:0] rows_setting = RCNT_W'(MAX_ROWS);
    logic [CCNT_W-1:0] cols_setting = CCNT_W'(MAX_COLS);

    t_edit_result pending_results[$];
    int unsigned  beats_sent, results_seen, applied_seen, reg_writes, fail_count;
    int unsigned  burst_left, gap;

    function automatic t_edit_result predict_edit(input t_edit_item it);
        int unsigned  rlim, clim, x, y, len, i, p;
        t_edit_result r;
        rlim = rows_setting;
        if (rlim < 1) rlim = 1;
        if (rlim > MAX_ROWS) rlim = MAX_ROWS;
        clim = cols_setting;
        if (clim < 1) clim = 1;
        if (clim > MAX_COLS) clim = MAX_COLS;
        r = '0;
        x = cursor_r;
        y = cursor_c;
        len = line_len[x];
        case (it.func)
            F_LOAD_CH: begin
                if (it.ch != 0 && load_row_m < rlim && line_len[load_row_m] < clim) begin
                    text_cells[load_row_m][line_len[load_row_m]] = it.ch;
                    line_len[load_row_m]++;
                    r.applied = 1'b1;
                end
            end
            F_LOAD_EOL: begin
                if (load_row_m < rlim) load_row_m++;
            end
            F_LEFT: begin
                if (x > 0 && y == 0) begin
                    x--;
                    y = line_len[x];
                    r.applied = 1'b1;
                end else if (y > 0) begin
                    y--;
                    r.applied = 1'b1;
                end
            end
            F_RIGHT: begin
                if (x + 1 < rlim && y == len) begin
                    x++;
                    y = 0;
                    r.applied = 1'b1;
                end else if (y < len) begin
                    y++;
                    r.applied = 1'b1;
                end
            end
            F_DELETE: begin
                if (y < len) begin
                    for (i = y; i + 1 < len; i++) text_cells[x][i] = text_cells[x][i + 1];
                    line_len[x] = len - 1;
                    r.applied = 1'b1;
                end
            end
            F_INSERT: begin
                if (it.ch != 0 && len < clim && y <= len) begin
                    for (i = len; i > y; i--) text_cells[x][i] = text_cells[x][i - 1];
                    text_cells[x][y] = it.ch;
                    line_len[x] = len + 1;
                    r.applied = 1'b1;
                end
            end
            F_READ: begin
                if (it.read_col < line_len[it.read_row])
                    r.cell_char = text_cells[it.read_row][it.read_col];
            end
            default: ;
        endcase
        cursor_r = x;
        cursor_c = y;
        // Only rows below the active row count take part in the print range.
        p = 0;
        for (i = 0; i < rlim; i++) if (line_len[i] != 0) p = i + 1;
        r.cursor_row  = ROW_W'(x);
        r.cursor_col  = CCNT_W'(y);
        r.line_length = CCNT_W'(line_len[x]);
        r.print_rows  = RCNT_W'(p);
        return r;
    endfunction

    function automatic t_edit_item random_edit();
        t_edit_item  it;
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 30) it.func = F_LOAD_CH;
        else if (pick < 38) it.func = F_LOAD_EOL;
        else if (pick < 50) it.func = F_LEFT;
        else if (pick < 65) it.func = F_RIGHT;
        else if (pick < 75) it.func = F_DELETE;
        else if (pick < 87) it.func = F_INSERT;
        else if (pick < 98) it.func = F_READ;
        else it.func = F_NOP;
        it.ch = ($urandom_range(0, 19) == 0) ? '0 : CHAR_W'($urandom_range(1, 255));
        // Reads favor the top rows and first columns, where the text usually is.
        it.read_row = ($urandom_range(0, 9) < 7) ? ROW_W'($urandom_range(0, 7))
                                                  : ROW_W'($urandom);
        it.read_col = ($urandom_range(0, 9) < 7) ? COL_W'($urandom_range(0, 15))
                                                  : COL_W'($urandom);
        return it;
    endfunction

    function automatic t_step beat(t_func f, int unsigned ch, int unsigned rr, int unsigned rc);
        t_step s;
        s = '{default: '0};
        s.item = '{func: f, ch: CHAR_W'(ch), read_row: ROW_W'(rr), read_col: COL_W'(rc)};
        return s;
    endfunction

    function automatic t_step beat_chk(t_func f, int unsigned ch, int unsigned rr,
                                       int unsigned rc, t_edit_result want);
        t_step s;
        s = beat(f, ch, rr, rc);
        s.typed = 1'b1;
        s.want = want;
        return s;
    endfunction

    function automatic t_edit_result outcome(int unsigned crow, int unsigned ccol,
                                             int unsigned cchar, int unsigned llen,
                                             int unsigned prows, int unsigned app);
        return '{cursor_row: ROW_W'(crow), cursor_col: CCNT_W'(ccol),
                 cell_char: CHAR_W'(cchar), line_length: CCNT_W'(llen),
                 print_rows: RCNT_W'(prows), applied: app[0]};
    endfunction

    function automatic t_step reg_step(logic [PADDR_W-1:0] addr, int unsigned value);
        t_step s;
        s = '{default: '0};
        s.is_reg = 1'b1;
        s.addr = addr;
        s.value = PDATA_W'(value);
        return s;
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endfunction

    // Registers change only with the editor idle: no beat offered, every result drained.
    task automatic write_reg(input logic [PADDR_W-1:0] addr, input logic [PDATA_W-1:0] data);
        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        pwrite <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== data) begin
            $error("register %0d readback: expected %0d, got %0d", addr, data, prdata);
            fail_count++;
        end
        psel <= 1'b0;
        penable <= 1'b0;
        if (addr == ADDR_ROWS) rows_setting = data[RCNT_W-1:0];
        else cols_setting = data[CCNT_W-1:0];
        reg_writes++;
        burst_left = 0;
    endtask

    task automatic send_edit(input t_edit_item it, input bit typed, input t_edit_result want);
        t_edit_result predicted;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap != 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_valid <= 1'b1;
        i_func <= it.func;
        i_ch <= it.ch;
        i_read_row <= it.read_row;
        i_read_col <= it.read_col;
        do @(posedge i_clk); while (!o_ready);
        predicted = predict_edit(it);
        pending_results.push_back(typed ? want : predicted);
        beats_sent++;
    endtask

    initial begin : sender
        t_step       directed[$];
        int unsigned phase, k, rows_v, cols_v;
        foreach (line_len[r]) line_len[r] = 0;
        cursor_r = 0;
        cursor_c = 0;
        load_row_m = 0;

        directed.push_back(beat_chk(F_READ, 0, 0, 0, outcome(0, 0, 0, 0, 0, 0)));
        directed.push_back(beat_chk(F_LEFT, 0, 0, 0, outcome(0, 0, 0, 0, 0, 0)));
        directed.push_back(beat_chk(F_RIGHT, 0, 0, 0, outcome(1, 0, 0, 0, 0, 1)));
        directed.push_back(beat_chk(F_LEFT, 0, 0, 0, outcome(0, 0, 0, 0, 0, 1)));
        directed.push_back(beat_chk(F_LOAD_CH, 0, 0, 0, outcome(0, 0, 0, 0, 0, 0)));
        directed.push_back(beat_chk(F_LOAD_CH, 8'h41, 0, 0, outcome(0, 0, 0, 1, 1, 1)));
        directed.push_back(beat(F_LOAD_CH, 8'hFF, 0, 0));
        directed.push_back(beat(F_LOAD_EOL, 0, 0, 0));
        directed.push_back(beat(F_LOAD_CH, 8'h01, 0, 0));
        directed.push_back(beat(F_RIGHT, 0, 0, 0));
        directed.push_back(beat(F_RIGHT, 0, 0, 0));
        directed.push_back(beat(F_RIGHT, 0, 0, 0));
        directed.push_back(beat(F_LEFT, 0, 0, 0));
        directed.push_back(beat(F_INSERT, 0, 0, 0));
        directed.push_back(beat(F_INSERT, 8'h80, 0, 0));
        directed.push_back(beat(F_LEFT, 0, 0, 0));
        directed.push_back(beat(F_DELETE, 0, 0, 0));
        directed.push_back(beat(F_DELETE, 0, 0, 0));
        directed.push_back(beat(F_DELETE, 0, 0, 0));
        directed.push_back(beat(F_READ, 0, 63, 127));
        directed.push_back(beat(F_NOP, 8'hFF, 63, 127));
        // Single row and single column: loads drop, end of line saturates, inserts refuse.
        directed.push_back(reg_step(ADDR_ROWS, 1));
        directed.push_back(reg_step(ADDR_COLS, 1));
        directed.push_back(beat(F_LOAD_CH, 8'h43, 0, 0));
        directed.push_back(beat(F_LOAD_EOL, 0, 0, 0));
        directed.push_back(beat(F_INSERT, 8'h55, 0, 0));
        // Zero settings behave as one; the widest values behave as the grid size.
        directed.push_back(reg_step(ADDR_ROWS, 0));
        directed.push_back(reg_step(ADDR_COLS, 0));
        directed.push_back(beat(F_RIGHT, 0, 0, 0));
        directed.push_back(reg_step(ADDR_ROWS, 127));
        directed.push_back(reg_step(ADDR_COLS, 255));
        directed.push_back(beat(F_READ, 0, 1, 0));

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed[n]) begin
            if (directed[n].is_reg) write_reg(directed[n].addr, directed[n].value);
            else send_edit(directed[n].item, directed[n].typed, directed[n].want);
        end

        for (phase = 0; phase < 5; phase++) begin
            case ($urandom_range(0, 5))
                0: begin rows_v = MAX_ROWS; cols_v = MAX_COLS; end
                1: begin rows_v = 1; cols_v = 1; end
                2: begin rows_v = $urandom_range(1, 8); cols_v = $urandom_range(1, 12); end
                3: begin rows_v = 127; cols_v = 255; end
                4: begin rows_v = 0; cols_v = 0; end
                default: begin
                    rows_v = $urandom_range(1, MAX_ROWS);
                    cols_v = $urandom_range(1, MAX_COLS);
                end
            endcase
            write_reg(ADDR_ROWS, PDATA_W'(rows_v));
            write_reg(ADDR_COLS, PDATA_W'(cols_v));
            for (k = 0; k < 110; k++) send_edit(random_edit(), 1'b0, '0);
        end
        i_valid <= 1'b0;

        for (k = 0; k < 20000 && pending_results.size() != 0; k++) @(posedge i_clk);
        if (pending_results.size() != 0) begin
            $error("%0d result beats never arrived", pending_results.size());
            fail_count++;
        end
        repeat (300) @(posedge i_clk);

        $display("Sent %0d edit beats over %0d register writes; %0d results checked, %0d applied.",
                 beats_sent, reg_writes, results_seen, applied_seen);
        $display("The receiver held off once for a long stretch while beats kept coming.");
        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    initial begin : receiver
        int unsigned mode, span;
        bit          held_off;
        held_off = 1'b0;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            // One long stall so the editor backs up and holds off its input.
            if (!held_off && results_seen >= 150) begin
                held_off = 1'b1;
                i_ready <= 1'b0;
                repeat (400) @(posedge i_clk);
            end
            mode = $urandom_range(0, 3);
            span = $urandom_range(4, 60);
            repeat (span) begin
                case (mode)
                    0: i_ready <= 1'b1;
                    1: i_ready <= 1'($urandom_range(0, 1));
                    2: i_ready <= ($urandom_range(0, 3) == 0);
                    default: i_ready <= ($urandom_range(0, 7) != 0);
                endcase
                @(posedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin : result_monitor
        t_edit_result w;
        if (i_rst_n && o_valid === 1'b1 && i_ready) begin
            if (pending_results.size() == 0) begin
                $error("result beat arrived with nothing expected");
                fail_count++;
            end else begin
                w = pending_results.pop_front();
                check_field("cursor_row", 32'(w.cursor_row), 32'(o_cursor_row));
                check_field("cursor_col", 32'(w.cursor_col), 32'(o_cursor_col));
                check_field("cell_char", 32'(w.cell_char), 32'(o_cell_char));
                check_field("line_length", 32'(w.line_length), 32'(o_line_length));
                check_field("print_rows", 32'(w.print_rows), 32'(o_print_rows));
                check_field("applied", 32'(w.applied), 32'(o_applied));
                results_seen++;
                if (w.applied) applied_seen++;
            end
        end
    end

    initial begin : watchdog
        #1_500_000;
        $display("simulation failed");
        $finish;
    end

endmodule
